>>> design/irdp_pkg.sv
// ---------------------------------------------------------------------------
// irdp_pkg
// Shared types, constants and helper functions of the interval removal
// energy block.
// ---------------------------------------------------------------------------
package irdp_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int SPAN         = MAX_ELEMENTS + 2;
    localparam int IDX_W        = $clog2(SPAN);
    localparam int TABLE_DEPTH  = SPAN * SPAN;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int STACK_DEPTH  = 64;
    localparam int STK_AW       = $clog2(STACK_DEPTH);
    localparam int SP_W         = STK_AW + 1;
    localparam int POT_W        = 16;
    localparam int CLS_W        = 3;
    localparam int AFF_W        = 3;
    localparam int PROD_W       = 2 * POT_W;
    localparam int TERM_W       = PROD_W + AFF_W;
    localparam int E_W          = 48;

    localparam logic [CLS_W-1:0] CLASS_NEUTRAL = 3'd4;

    // one pair of chain element fields
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [POT_W-1:0] pot;
    } elem_t;

    // pending node of the choice tree walk
    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             visited;
    } frame_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SPAN,
        ST_SPAN2,
        ST_KRD,
        ST_KM1,
        ST_KM2,
        ST_KAC,
        ST_KCMP,
        ST_WR,
        ST_ENERGY,
        ST_TINIT,
        ST_POP,
        ST_FRAME,
        ST_CHOICE,
        ST_PUSHR,
        ST_PUSHL,
        ST_OUT
    } state_t;

    // affinity between two classes; neutral or unknown codes give one
    function automatic logic [AFF_W-1:0] aff(input logic [CLS_W-1:0] a,
                                            input logic [CLS_W-1:0] b);
        logic [AFF_W-1:0] v;
        begin
            v = 3'd1;
            if (a < 3'd4 && b < 3'd4)
            begin
                case ({a[1:0], b[1:0]})
                    4'b0000: v = 3'd0;
                    4'b0001: v = 3'd4;
                    4'b0010: v = 3'd1;
                    4'b0011: v = 3'd0;
                    4'b0100: v = 3'd2;
                    4'b0101: v = 3'd3;
                    4'b0110: v = 3'd3;
                    4'b0111: v = 3'd1;
                    4'b1000: v = 3'd0;
                    4'b1001: v = 3'd1;
                    4'b1010: v = 3'd1;
                    4'b1011: v = 3'd5;
                    4'b1100: v = 3'd1;
                    4'b1101: v = 3'd3;
                    4'b1110: v = 3'd3;
                    4'b1111: v = 3'd1;
                    default: v = 3'd1;
                endcase
            end
            return v;
        end
    endfunction

    // flat table address of span lo..hi
    function automatic logic [ADDR_W-1:0] span_addr(input logic [IDX_W-1:0] lo,
                                                    input logic [IDX_W-1:0] hi);
        return ADDR_W'(32'(lo) * SPAN + 32'(hi));
    endfunction

endpackage

>>> design/irdp_mul.sv
// ---------------------------------------------------------------------------
// irdp_mul
// Shared potential multiplier: one registered 16 x 16 product per cycle.
// ---------------------------------------------------------------------------
module irdp_mul (
    input  logic                       clk,
    input  logic [irdp_pkg::POT_W-1:0]  a,
    input  logic [irdp_pkg::POT_W-1:0]  b,
    output logic [irdp_pkg::PROD_W-1:0] p
);
    import irdp_pkg::*;

    // register the product for the next step of the sequencer
    always_ff @(posedge clk)
    begin
        p <= PROD_W'(a) * PROD_W'(b);
    end

endmodule

>>> design/interval_removal_energy_dp.sv
// ---------------------------------------------------------------------------
// interval_removal_energy_dp
// Interval removal energy search with removal order readout.
// ---------------------------------------------------------------------------
// Elements load at one transfer per cycle; up to 32 are kept and further ones
// are dropped. The transfer with tlast starts the span search, during which
// s_axis_tready is low. The search visits every span l..r and every choice k;
// per choice it reads element k and the sub-span energies, forms the left and
// right products on the one shared multiplier, adds the scaled terms and
// compares. Then the energy result goes out, followed by n removal indices in
// post-order, the last with tlast. The stack walk expands each frame (pop,
// latch, push back as visited, push right and left sub-spans) and later pops
// it again and sends its index, waiting while the output register is still
// held by a stalled receiver.
// ---------------------------------------------------------------------------
module interval_removal_energy_dp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [15:0] potential, [18:16] class_code
    input  logic        s_axis_tlast,  // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [47:0] result_value
    output logic [0:0]  m_axis_tuser,  // [0] result_kind
    output logic        m_axis_tlast   // last_result
);
    import irdp_pkg::*;

    // control registers
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [IDX_W-1:0]  n_reg, n_next, l_reg, l_next, r_reg, r_next;
    logic [IDX_W-1:0]  k_reg, k_next, choice_reg, choice_next, c_reg, c_next;
    logic [POT_W-1:0]  pl_reg, pl_next, pr_reg, pr_next, pk_reg, pk_next;
    logic [CLS_W-1:0]  cl_reg, cl_next, cr_reg, cr_next, ck_reg, ck_next;
    logic [E_W-1:0]    esum_reg, esum_next, acc_reg, acc_next;
    logic [E_W-1:0]    total_reg, total_next, best_reg, best_next;
    frame_t            fr_reg, fr_next;
    logic [E_W-1:0]    out_value_reg, out_value_next;
    logic              out_kind_reg, out_kind_next, out_last_reg, out_last_next;

    // memories
    elem_t             el_mem [SPAN];
    logic [E_W-1:0]    en_mem [TABLE_DEPTH];
    logic [IDX_W-1:0]  ch_mem [TABLE_DEPTH];
    frame_t            st_mem [STACK_DEPTH];

    logic              el_we, en_we, st_we, out_load;
    logic [IDX_W-1:0]  el_waddr, el_raddr_a, el_raddr_b;
    elem_t             el_wdata, el_q_a, el_q_b;
    logic [ADDR_W-1:0] en_waddr, en_raddr_a, en_raddr_b, ch_raddr;
    logic [E_W-1:0]    en_q_a, en_q_b;
    logic [IDX_W-1:0]  ch_q;
    logic [STK_AW-1:0] st_waddr, st_raddr;
    frame_t            st_wdata, st_q;

    logic [POT_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_q;
    logic [IDX_W-1:0]  cnt_inc;
    logic              out_free, sp_room;

    irdp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_q)
    );

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign sp_room  = (sp_reg < SP_W'(STACK_DEPTH));

    // element store
    always_ff @(posedge clk)
    begin
        if (el_we)
        begin
            el_mem[el_waddr] <= el_wdata;
        end
        el_q_a <= el_mem[el_raddr_a];
        el_q_b <= el_mem[el_raddr_b];
    end

    // best energy and best choice tables
    always_ff @(posedge clk)
    begin
        if (en_we)
        begin
            en_mem[en_waddr] <= best_reg;
            ch_mem[en_waddr] <= choice_reg;
        end
        en_q_a <= en_mem[en_raddr_a];
        en_q_b <= en_mem[en_raddr_b];
        ch_q   <= ch_mem[ch_raddr];
    end

    // traversal stack
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_q <= st_mem[st_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        k_reg         <= k_next;
        choice_reg    <= choice_next;
        c_reg         <= c_next;
        pl_reg        <= pl_next;
        pr_reg        <= pr_next;
        pk_reg        <= pk_next;
        cl_reg        <= cl_next;
        cr_reg        <= cr_next;
        ck_reg        <= ck_next;
        esum_reg      <= esum_next;
        acc_reg       <= acc_next;
        total_reg     <= total_next;
        best_reg      <= best_next;
        fr_reg        <= fr_next;
        out_value_reg <= out_value_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        n_next         = n_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        choice_next    = choice_reg;
        c_next         = c_reg;
        pl_next        = pl_reg;
        pr_next        = pr_reg;
        pk_next        = pk_reg;
        cl_next        = cl_reg;
        cr_next        = cr_reg;
        ck_next        = ck_reg;
        esum_next      = esum_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        best_next      = best_reg;
        fr_next        = fr_reg;
        out_load       = 1'b0;
        out_value_next = out_value_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        el_we      = 1'b0;
        el_waddr   = count_reg + IDX_W'(1);
        el_wdata   = '{cls: s_axis_tdata[18:16], pot: s_axis_tdata[15:0]};
        el_raddr_a = k_reg;
        el_raddr_b = r_reg + IDX_W'(1);
        en_we      = 1'b0;
        en_waddr   = span_addr(l_reg, r_reg);
        en_raddr_a = span_addr(l_reg, k_reg - IDX_W'(1));
        en_raddr_b = span_addr(k_reg + IDX_W'(1), r_reg);
        ch_raddr   = span_addr(st_q.lo, st_q.hi);
        st_we      = 1'b0;
        st_waddr   = sp_reg[STK_AW-1:0];
        st_wdata   = '{lo: fr_reg.lo, hi: fr_reg.hi, visited: 1'b1};
        st_raddr   = sp_reg[STK_AW-1:0] - STK_AW'(1);
        mul_a      = pr_reg;
        mul_b      = pk_reg;
        cnt_inc    = count_reg;

        case (state_reg)
            // store elements, start the search on the last one
            ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (count_reg < IDX_W'(MAX_ELEMENTS))
                    begin
                        el_we   = 1'b1;
                        cnt_inc = count_reg + IDX_W'(1);
                    end
                    count_next = cnt_inc;
                    if (s_axis_tlast)
                    begin
                        n_next     = cnt_inc;
                        l_next     = cnt_inc;
                        r_next     = cnt_inc;
                        state_next = ST_SPAN;
                    end
                end
            end
            // fetch the span's outer neighbors
            ST_SPAN:
            begin
                el_raddr_a  = l_reg - IDX_W'(1);
                best_next   = '0;
                choice_next = l_reg;
                k_next      = l_reg;
                state_next  = ST_SPAN2;
            end
            // latch neighbors, ends read as potential one and neutral
            ST_SPAN2:
            begin
                if (l_reg == IDX_W'(1))
                begin
                    pl_next = POT_W'(1);
                    cl_next = CLASS_NEUTRAL;
                end
                else
                begin
                    pl_next = el_q_a.pot;
                    cl_next = el_q_a.cls;
                end
                if (r_reg == n_reg)
                begin
                    pr_next = POT_W'(1);
                    cr_next = CLASS_NEUTRAL;
                end
                else
                begin
                    pr_next = el_q_b.pot;
                    cr_next = el_q_b.cls;
                end
                state_next = ST_KRD;
            end
            // read element k and both sub-span energies
            ST_KRD:
            begin
                state_next = ST_KM1;
            end
            // left product; sum sub-spans, empty ones count zero
            ST_KM1:
            begin
                mul_a     = pl_reg;
                mul_b     = el_q_a.pot;
                pk_next   = el_q_a.pot;
                ck_next   = el_q_a.cls;
                esum_next = ((k_reg == l_reg) ? '0 : en_q_a)
                          + ((k_reg == r_reg) ? '0 : en_q_b);
                state_next = ST_KM2;
            end
            // right product; add scaled left term
            ST_KM2:
            begin
                mul_a      = pr_reg;
                mul_b      = pk_reg;
                acc_next   = esum_reg
                           + E_W'(TERM_W'(mul_q) * TERM_W'(aff(cl_reg, ck_reg)));
                state_next = ST_KAC;
            end
            // add scaled right term
            ST_KAC:
            begin
                total_next = acc_reg
                           + E_W'(TERM_W'(mul_q) * TERM_W'(aff(ck_reg, cr_reg)));
                state_next = ST_KCMP;
            end
            // keep the best, ties to the larger k
            ST_KCMP:
            begin
                if (total_reg >= best_reg)
                begin
                    best_next   = total_reg;
                    choice_next = k_reg;
                end
                if (k_reg == r_reg)
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_KRD;
                end
            end
            // store the span result and advance the span
            ST_WR:
            begin
                en_we = 1'b1;
                if (r_reg == n_reg)
                begin
                    if (l_reg == IDX_W'(1))
                    begin
                        state_next = ST_ENERGY;
                    end
                    else
                    begin
                        l_next     = l_reg - IDX_W'(1);
                        r_next     = l_reg - IDX_W'(1);
                        state_next = ST_SPAN;
                    end
                end
                else
                begin
                    r_next     = r_reg + IDX_W'(1);
                    state_next = ST_SPAN;
                end
            end
            // send the total energy
            ST_ENERGY:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = 1'b0;
                    out_value_next = best_reg;
                    out_last_next  = 1'b0;
                    state_next     = ST_TINIT;
                end
            end
            // push the whole chain as the root frame
            ST_TINIT:
            begin
                st_we      = 1'b1;
                st_waddr   = '0;
                st_wdata   = '{lo: IDX_W'(1), hi: n_reg, visited: 1'b0};
                sp_next    = SP_W'(1);
                state_next = ST_POP;
            end
            // pop a frame, or finish the run
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    count_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = ST_FRAME;
                end
            end
            // latch the frame and read its choice
            ST_FRAME:
            begin
                fr_next    = st_q;
                state_next = ST_CHOICE;
            end
            // emit a visited frame, else push it back as visited
            ST_CHOICE:
            begin
                c_next = ch_q;
                if (fr_reg.visited)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    if (sp_room)
                    begin
                        st_we   = 1'b1;
                        sp_next = sp_reg + SP_W'(1);
                    end
                    state_next = ST_PUSHR;
                end
            end
            // push the right sub-span
            ST_PUSHR:
            begin
                st_wdata = '{lo: c_reg + IDX_W'(1), hi: fr_reg.hi, visited: 1'b0};
                if ((c_reg + IDX_W'(1) <= fr_reg.hi) && sp_room)
                begin
                    st_we   = 1'b1;
                    sp_next = sp_reg + SP_W'(1);
                end
                state_next = ST_PUSHL;
            end
            // push the left sub-span
            ST_PUSHL:
            begin
                st_wdata = '{lo: fr_reg.lo, hi: c_reg - IDX_W'(1), visited: 1'b0};
                if ((c_reg > fr_reg.lo) && sp_room)
                begin
                    st_we   = 1'b1;
                    sp_next = sp_reg + SP_W'(1);
                end
                state_next = ST_POP;
            end
            // send one removal index, the root one last
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = 1'b1;
                    out_value_next = E_W'(c_reg);
                    out_last_next  = (fr_reg.lo == IDX_W'(1)) && (fr_reg.hi == n_reg);
                    state_next     = ST_POP;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // output register: load a new result or drop a taken one
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // chain length stays within the element store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IDX_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // stack pointer stays within the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer overflow");

    // choice under test lies inside its span
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KCMP) |-> (k_reg >= l_reg && k_reg <= r_reg))
        else $error("choice outside span");

    // the final result of a run is a removal index
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("last result is not an index");

endmodule
